FILE: hdl/slcd_pkg.sv
`timescale 1ns / 1ps

package slcd_pkg;

    // Field and counter widths
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 32;
    localparam int LEN_EXT_W   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Frame geometry
    localparam int MAX_FRAME_DEF  = 64;
    localparam int FRAME_OVERHEAD = 3;
    localparam int MIN_FRAME      = 5;

    // Depth of the queue between parser and counter stage
    localparam int QUEUE_DEPTH = 4;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_TYPE   = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST     = 8'h7E;
    localparam logic [BYTE_W-1:0] REPORT_LENGTH_RST = 8'h2F;
    localparam logic [BYTE_W-1:0] REPORT_TYPE_RST   = 8'h31;

    // Event codes of a result
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_FRAME  = 2'd1,
        EV_RESYNC = 2'd2
    } t_event;

    // Classified byte, passed from parser to counter stage
    typedef struct packed {
        t_event             event_res;
        logic [BYTE_W-1:0]  frame_length;
        logic [BYTE_W-1:0]  frame_type;
        logic               checksum_good;
        logic               status_report;
    } t_cls;

endpackage

FILE: hdl/slcd_byte_if.sv
`timescale 1ns / 1ps

interface slcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/slcd_result_if.sv
`timescale 1ns / 1ps

interface slcd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  frame_length;
    logic [7:0]  frame_type;
    logic        checksum_good;
    logic        status_report;
    logic [31:0] byte_total;
    logic [31:0] frame_total;
    logic [31:0] bad_checksum_total;
    logic [31:0] resync_total;
    logic [31:0] report_total;

    modport source (
        output valid, output event_res, output frame_length, output frame_type,
        output checksum_good, output status_report, output byte_total,
        output frame_total, output bad_checksum_total, output resync_total,
        output report_total, input ready
    );
    modport sink (
        input valid, input event_res, input frame_length, input frame_type,
        input checksum_good, input status_report, input byte_total,
        input frame_total, input bad_checksum_total, input resync_total,
        input report_total, output ready
    );
endinterface

FILE: hdl/slcd_front.sv
`timescale 1ns / 1ps

module slcd_front #(
    parameter int MAX_FRAME = slcd_pkg::MAX_FRAME_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    input  logic [slcd_pkg::BYTE_W-1:0]     i_byte,
    output logic                            o_ready,
    input  logic                            i_full,
    output logic                            o_push,
    output slcd_pkg::t_cls                  o_cls
);
    import slcd_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam logic [POS_W-1:0] POS_SYNC1 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC2 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME);

    logic [BYTE_W-1:0] r_sync, r_rlen, r_rtype;
    logic [POS_W-1:0]  r_pos, n_pos, r_size, n_size;
    logic [BYTE_W-1:0] r_len, n_len, r_type, n_type, r_sum, n_sum;
    logic [POS_W-1:0]  w_pos_inc;
    logic [LEN_EXT_W-1:0] w_expected;
    logic              w_accept, w_good;
    t_cls              w_cls;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept;
    assign o_cls    = w_cls;

    assign w_pos_inc  = r_pos + POS_W'(1);
    assign w_expected = LEN_EXT_W'(i_byte) + LEN_EXT_W'(FRAME_OVERHEAD);
    assign w_good     = (r_sum == i_byte);

    // Classify the byte against the current frame position
    always_comb begin
        n_pos  = r_pos;
        n_size = r_size;
        n_len  = r_len;
        n_type = r_type;
        n_sum  = r_sum;
        w_cls  = '{event_res: EV_NONE, frame_length: '0, frame_type: '0,
                   checksum_good: 1'b0, status_report: 1'b0};
        priority if (r_pos == POS_SYNC1) begin
            if (i_byte == r_sync) begin
                n_pos = POS_SYNC2;
            end
        end else if (r_pos == POS_SYNC2) begin
            if (i_byte == r_sync) begin
                n_pos = POS_LEN;
            end else begin
                n_pos           = POS_SYNC1;
                n_size          = '0;
                w_cls.event_res = EV_RESYNC;
            end
        end else if (r_pos == POS_LEN) begin
            if (w_expected < LEN_EXT_W'(MIN_FRAME) || w_expected > LEN_EXT_W'(MAX_FRAME)) begin
                n_pos           = POS_SYNC1;
                n_size          = '0;
                w_cls.event_res = EV_RESYNC;
            end else begin
                n_size = POS_W'(w_expected);
                n_len  = i_byte;
                n_sum  = i_byte;
                n_pos  = POS_TYPE;
            end
        end else if (r_pos >= POS_LIMIT) begin
            // guard against a runaway position
            n_pos           = POS_SYNC1;
            n_size          = '0;
            w_cls.event_res = EV_RESYNC;
        end else begin
            if (r_pos == POS_TYPE) begin
                n_type = i_byte;
            end
            n_pos = w_pos_inc;
            if (r_size != '0 && w_pos_inc == r_size) begin
                w_cls.event_res     = EV_FRAME;
                w_cls.frame_length  = r_len;
                w_cls.frame_type    = n_type;
                w_cls.checksum_good = w_good;
                w_cls.status_report = w_good && (r_len == r_rlen) && (n_type == r_rtype);
                n_pos               = POS_SYNC1;
                n_size              = '0;
            end else begin
                n_sum = r_sum + i_byte;
            end
        end
    end

    // Hold parser state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= SYNC_BYTE_RST;
            r_rlen  <= REPORT_LENGTH_RST;
            r_rtype <= REPORT_TYPE_RST;
            r_pos   <= '0;
            r_size  <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_sum   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SYNC_BYTE:     r_sync  <= i_cfg_data;
                    REG_REPORT_LENGTH: r_rlen  <= i_cfg_data;
                    REG_REPORT_TYPE:   r_rtype <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_pos  <= n_pos;
                r_size <= n_size;
                r_len  <= n_len;
                r_type <= n_type;
                r_sum  <= n_sum;
            end
        end
    end

endmodule

FILE: hdl/slcd_queue.sv
`timescale 1ns / 1ps

module slcd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slcd_pkg::t_cls i_cls,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output slcd_pkg::t_cls o_cls
);
    import slcd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cls               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_QW-1:0]  r_cnt;
    logic               w_pop;

    assign o_full  = (r_cnt == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_QW'(1);
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - CNT_QW'(1);
            end
        end
    end

endmodule

FILE: hdl/slcd_back.sv
`timescale 1ns / 1ps

module slcd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  slcd_pkg::t_cls             i_cls,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output slcd_pkg::t_cls             o_cls,
    output logic [slcd_pkg::CNT_W-1:0] o_bytes,
    output logic [slcd_pkg::CNT_W-1:0] o_frames,
    output logic [slcd_pkg::CNT_W-1:0] o_bad,
    output logic [slcd_pkg::CNT_W-1:0] o_resync,
    output logic [slcd_pkg::CNT_W-1:0] o_reports
);
    import slcd_pkg::*;

    logic             r_valid;
    t_cls             r_cls;
    logic [CNT_W-1:0] r_bytes, r_frames, r_bad, r_resync, r_reports;
    logic             w_load, w_frame;

    assign o_pop     = i_valid && (!r_valid || i_ready);
    assign w_load    = o_pop;
    assign w_frame   = (i_cls.event_res == EV_FRAME);
    assign o_valid   = r_valid;
    assign o_cls     = r_cls;
    assign o_bytes   = r_bytes;
    assign o_frames  = r_frames;
    assign o_bad     = r_bad;
    assign o_resync  = r_resync;
    assign o_reports = r_reports;

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cls <= i_cls;
        end
    end

    // Update counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_bytes   <= '0;
            r_frames  <= '0;
            r_bad     <= '0;
            r_resync  <= '0;
            r_reports <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_bytes <= r_bytes + CNT_W'(1);
                if (w_frame) begin
                    r_frames <= r_frames + CNT_W'(1);
                end
                if (w_frame && !i_cls.checksum_good) begin
                    r_bad <= r_bad + CNT_W'(1);
                end
                if (i_cls.event_res == EV_RESYNC) begin
                    r_resync <= r_resync + CNT_W'(1);
                end
                if (i_cls.status_report) begin
                    r_reports <= r_reports + CNT_W'(1);
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/sync_length_checksum_deframer.sv
`timescale 1ns / 1ps

// Channel   | Dir | Payload                                  | Transaction
// i_byte    | in  | rx_byte                                  | valid & ready
// o_res     | out | event, frame facts, five 32-bit counters | valid & ready
// cfg write | in  | i_cfg_idx, i_cfg_data                    | i_cfg_we
//
// One byte per cycle while the queue has room; a result passes through the queue and then the output register.
// The parser position register closes the parser's feedback loop; counters add once per result.
// Reset: registers to 0x7E/0x2F/0x31, parser and counters to zero; no clearing pass.
// A four-entry queue between parser and counter stage absorbs output stalls;
// the input stalls only when that queue is full.

module sync_length_checksum_deframer #(
    parameter int MAX_FRAME = slcd_pkg::MAX_FRAME_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    slcd_byte_if.sink                       i_byte,
    slcd_result_if.source                   o_res
);
    import slcd_pkg::*;

    logic             w_full, w_push, w_qvalid, w_pop;
    t_cls             w_front_cls, w_queue_cls, w_out_cls;
    logic [CNT_W-1:0] w_bytes, w_frames, w_bad, w_resync, w_reports;

    // Parser: accept and classify bytes
    slcd_front #(
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_byte.valid),
        .i_byte     (i_byte.rx_byte),
        .o_ready    (i_byte.ready),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cls      (w_front_cls)
    );

    // Decouple parser from counter stage
    slcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_front_cls),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_cls   (w_queue_cls)
    );

    // Counter stage and output register
    slcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_qvalid),
        .i_cls     (w_queue_cls),
        .o_pop     (w_pop),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_cls     (w_out_cls),
        .o_bytes   (w_bytes),
        .o_frames  (w_frames),
        .o_bad     (w_bad),
        .o_resync  (w_resync),
        .o_reports (w_reports)
    );

    assign o_res.event_res          = w_out_cls.event_res;
    assign o_res.frame_length       = w_out_cls.frame_length;
    assign o_res.frame_type         = w_out_cls.frame_type;
    assign o_res.checksum_good      = w_out_cls.checksum_good;
    assign o_res.status_report      = w_out_cls.status_report;
    assign o_res.byte_total         = w_bytes;
    assign o_res.frame_total        = w_frames;
    assign o_res.bad_checksum_total = w_bad;
    assign o_res.resync_total       = w_resync;
    assign o_res.report_total       = w_reports;

endmodule

FILE: hdl/slcd_checker.sv
`timescale 1ns / 1ps

module slcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_event,
    input logic [7:0]  i_flen,
    input logic [7:0]  i_ftype,
    input logic        i_good,
    input logic        i_report,
    input logic [31:0] i_bytes,
    input logic [31:0] i_frames
);
    import slcd_pkg::*;

    logic [31:0] r_last_bytes;
    logic        w_take;

    assign w_take = i_valid && i_ready;

    // Track byte count of the last delivered transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_bytes <= '0;
        end else if (w_take) begin
            r_last_bytes <= i_bytes;
        end
    end

    // Stalled result holds its counters
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_bytes) && $stable(i_frames))
        else $error("result changed while stalled");

    // Each delivered transaction counts exactly one more byte
    a_byte_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> i_bytes == r_last_bytes + 32'd1)
        else $error("byte total skipped or repeated");

    // Frame facts only on a completed frame
    a_frame_facts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_event != EV_FRAME |->
            i_flen == 8'd0 && i_ftype == 8'd0 && !i_good && !i_report)
        else $error("frame facts outside a completed frame");

    // A status report needs a good checksum
    a_report_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_report |-> i_good && i_event == EV_FRAME)
        else $error("status report without good frame");

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_event  (o_res.event_res),
    .i_flen   (o_res.frame_length),
    .i_ftype  (o_res.frame_type),
    .i_good   (o_res.checksum_good),
    .i_report (o_res.status_report),
    .i_bytes  (o_res.byte_total),
    .i_frames (o_res.frame_total)
);
